@@ sv/hkv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the hashed key-value store.
package hkv_pkg;

    localparam int BUCKET_COUNT_DEF = 1024;
    localparam int WAYS_DEF         = 4;
    localparam int KEY_W            = 32;
    localparam int VALUE_W          = 32;
    // Key bits folded into the bucket remainder per cycle
    localparam int HASH_CHUNK       = 8;
    // Wide enough for the largest supported way count
    localparam int WAY_IDX_W        = 4;

    localparam logic               MODE_WRITE = 1'b1;
    localparam logic [VALUE_W-1:0] NO_VALUE   = '1;

    typedef enum logic [1:0] {
        STATUS_WRITTEN   = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_UPDATE
    } state_t;

    // Lookup outcome of one bucket row: first matching way and first free way
    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic                 free;
        logic [WAY_IDX_W-1:0] free_way;
    } way_match_t;

    function automatic int index_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Two's complement magnitude; the most negative key maps to 2^31
    function automatic logic [KEY_W-1:0] key_magnitude(input logic [KEY_W-1:0] k);
        return k[KEY_W-1] ? (~k + KEY_W'(1)) : k;
    endfunction

endpackage

@@ sv/hkv_hash.sv @@
`timescale 1ns / 1ps
// Bucket index unit: magnitude of the key modulo the bucket count.
module hkv_hash #(
    parameter int  BUCKET_COUNT = hkv_pkg::BUCKET_COUNT_DEF,
    localparam int BW           = hkv_pkg::index_bits(BUCKET_COUNT)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hkv_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [BW-1:0]             bucket
);
    import hkv_pkg::*;

    localparam bit POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

    logic [KEY_W-1:0] mag_reg;

    // Capture the key magnitude at the start of each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg <= '0;
        end
        else if (start)
        begin
            mag_reg <= key_magnitude(key);
        end
    end

    generate
        if (POW2)
        begin : g_mask
            // Power-of-two bucket count: the remainder is a mask
            assign bucket = BW'(mag_reg & KEY_W'(BUCKET_COUNT - 1));
            assign done   = 1'b1;
        end
        else
        begin : g_iter
            localparam int RW     = BW + 1;
            localparam int CHUNKS = KEY_W / HASH_CHUNK;
            localparam int CW     = $clog2(CHUNKS + 1);
            localparam int SW     = index_bits(CHUNKS);

            logic [RW-1:0]         rem_reg;
            logic [RW-1:0]         rem_next;
            logic [CW-1:0]         cnt_reg;
            logic [SW-1:0]         sel;
            logic [HASH_CHUNK-1:0] chunk;

            assign done   = (cnt_reg == CW'(CHUNKS));
            assign bucket = rem_reg[BW-1:0];

            // Pick the next key chunk, most significant first
            always_comb
            begin
                sel   = done ? '0 : SW'(CHUNKS - 1 - int'(cnt_reg));
                chunk = mag_reg[sel*HASH_CHUNK +: HASH_CHUNK];
            end

            // Fold one chunk into the remainder, one conditional subtract per bit
            always_comb
            begin
                rem_next = rem_reg;
                for (int i = HASH_CHUNK - 1; i >= 0; i--)
                begin
                    rem_next = {rem_next[RW-2:0], chunk[i]};
                    if (rem_next >= RW'(BUCKET_COUNT))
                    begin
                        rem_next = rem_next - RW'(BUCKET_COUNT);
                    end
                end
            end

            // Restart on a new word, advance until all chunks are folded
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= CW'(CHUNKS);
                    rem_reg <= '0;
                end
                else if (start)
                begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                end
                else if (!done)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    rem_reg <= rem_next;
                end
            end
        end
    endgenerate

endmodule

@@ sv/hkv_mem.sv @@
`timescale 1ns / 1ps
// Bucket row memory: one write port and one registered read port.
module hkv_mem #(
    parameter int DEPTH = hkv_pkg::BUCKET_COUNT_DEF,
    parameter int AW    = hkv_pkg::index_bits(hkv_pkg::BUCKET_COUNT_DEF),
    parameter int W     = hkv_pkg::WAYS_DEF * (1 + hkv_pkg::KEY_W + hkv_pkg::VALUE_W)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    // Write a row, read a row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/hkv_match.sv @@
`timescale 1ns / 1ps
// Way compare: finds the first valid way holding the key and the first free way.
module hkv_match #(
    parameter int WAYS = hkv_pkg::WAYS_DEF
) (
    input  logic [WAYS-1:0]                     row_valid,
    input  logic [WAYS-1:0][hkv_pkg::KEY_W-1:0] row_key,
    input  logic [hkv_pkg::KEY_W-1:0]           key,
    output hkv_pkg::way_match_t                 result
);
    import hkv_pkg::*;

    // Scan from the top way down so the lowest-numbered way wins
    always_comb
    begin
        result = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_valid[w] && (row_key[w] == key))
            begin
                result.hit     = 1'b1;
                result.hit_way = WAY_IDX_W'(w);
            end
            if (!row_valid[w])
            begin
                result.free     = 1'b1;
                result.free_way = WAY_IDX_W'(w);
            end
        end
    end

endmodule

@@ sv/hashed_key_value_store.sv @@
`timescale 1ns / 1ps
// Hashed key-value store: top level.
// Input channel (in_valid/in_stall) carries mode, key and data_in; a read (mode 0)
// looks the key up, a write (mode 1) updates or inserts it. The output channel
// (out_valid/out_stall) returns one word per request: status and data_out.
// The key selects bucket |key| % BUCKET_COUNT, a row of WAYS entries in one memory.
// Each request reads the row once and compares all ways in parallel; a write that
// hits or finds a free way writes the row back in the cycle its result is
// registered, and a write to a full bucket stores nothing.
// Per request: bucket index (a mask when BUCKET_COUNT is a power of two, else the
// remainder folded 8 key bits per cycle), row read, compare and write-back.
// A new request is taken in the cycle the previous result is registered.
// Reset: the memory is swept one row per cycle to clear all valid bits; in_stall
// stays high until the sweep is done.
// Output stall: the result register holds its word; the block finishes at most
// one more request up to the write-back and waits there with the input stalled.
module hashed_key_value_store #(
    parameter int BUCKET_COUNT = hkv_pkg::BUCKET_COUNT_DEF,
    parameter int WAYS         = hkv_pkg::WAYS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [hkv_pkg::KEY_W-1:0]   key,
    input  logic [hkv_pkg::VALUE_W-1:0] data_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [hkv_pkg::VALUE_W-1:0] data_out
);
    import hkv_pkg::*;

    localparam int BW    = index_bits(BUCKET_COUNT);
    localparam int WYW   = index_bits(WAYS);
    localparam int ROW_W = WAYS * (1 + KEY_W + VALUE_W);

    state_t               state_reg;
    state_t               state_next;
    logic [BW-1:0]        clr_addr_reg;
    logic [BW-1:0]        clr_addr_next;
    logic                 mode_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [VALUE_W-1:0]   data_out_reg;
    logic [VALUE_W-1:0]   data_out_next;

    logic                 in_accept;
    logic                 slot_free;
    logic                 out_load;
    logic                 hash_done;
    logic [BW-1:0]        bucket;
    logic                 rd_en;
    logic                 wr_en;
    logic [BW-1:0]        wr_addr;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     wr_row;
    logic                 upd_write;
    way_match_t           match;
    logic [WYW-1:0]       hit_way;
    logic [WYW-1:0]       free_way;

    logic [WAYS-1:0]                row_valid;
    logic [WAYS-1:0][KEY_W-1:0]     row_key;
    logic [WAYS-1:0][VALUE_W-1:0]   row_value;
    logic [WAYS-1:0]                new_valid;
    logic [WAYS-1:0][KEY_W-1:0]     new_key;
    logic [WAYS-1:0][VALUE_W-1:0]   new_value;

    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    hkv_hash #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .key    (key),
        .done   (hash_done),
        .bucket (bucket)
    );

    hkv_mem #(
        .DEPTH (BUCKET_COUNT),
        .AW    (BW),
        .W     (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (bucket),
        .rd_data (rd_row)
    );

    assign {row_valid, row_key, row_value} = rd_row;

    hkv_match #(
        .WAYS (WAYS)
    ) u_match (
        .row_valid (row_valid),
        .row_key   (row_key),
        .key       (key_reg),
        .result    (match)
    );

    assign hit_way  = match.hit_way[WYW-1:0];
    assign free_way = match.free_way[WYW-1:0];

    // Build the updated row and the result word
    always_comb
    begin
        new_valid     = row_valid;
        new_key       = row_key;
        new_value     = row_value;
        upd_write     = 1'b0;
        status_next   = STATUS_NOT_FOUND;
        data_out_next = NO_VALUE;
        if (mode_reg == MODE_WRITE)
        begin
            if (match.hit)
            begin
                new_value[hit_way] = data_reg;
                upd_write          = 1'b1;
                status_next        = STATUS_WRITTEN;
            end
            else if (match.free)
            begin
                new_valid[free_way] = 1'b1;
                new_key[free_way]   = key_reg;
                new_value[free_way] = data_reg;
                upd_write           = 1'b1;
                status_next         = STATUS_WRITTEN;
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        else if (match.hit)
        begin
            status_next   = STATUS_FOUND;
            data_out_next = row_value[hit_way];
        end
    end

    // Sequence clear sweep, hash, row read and write-back
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        in_stall      = 1'b1;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = bucket;
        wr_row        = {new_valid, new_key, new_value};
        out_load      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_row        = '0;
                clr_addr_next = clr_addr_reg + BW'(1);
                if (clr_addr_reg == BW'(BUCKET_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    rd_en      = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    wr_en      = upd_write;
                    out_load   = 1'b1;
                    in_stall   = 1'b0;
                    state_next = in_valid ? S_HASH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            data_reg <= data_in;
        end
    end

    // Register the result word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;

endmodule

@@ sv/hkv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the hashed key-value store, bound to the top level.
module hkv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  status,
    input logic [hkv_pkg::VALUE_W-1:0] data_out
);
    import hkv_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out))
        else $error("result word changed while stalled");

    // Stall the input in the cycle after taking a word
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("two words taken in back-to-back cycles");

    // Return no value on a write result
    a_write_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_WRITTEN || status == STATUS_FULL)
        |-> data_out == NO_VALUE)
        else $error("write result carries a value");

    // Return no value on a miss
    a_miss_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_NOT_FOUND |-> data_out == NO_VALUE)
        else $error("miss result carries a value");

endmodule

bind hashed_key_value_store hkv_checker u_hkv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out)
);

@@ test/hashed_key_value_store_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the hashed key-value store: directed and random reads and writes.
module hashed_key_value_store_test;
    import hkv_pkg::*;

    localparam int          BUCKETS     = BUCKET_COUNT_DEF;
    localparam int          WAY_COUNT   = WAYS_DEF;
    localparam int          ENTRY_COUNT = BUCKETS * WAY_COUNT;
    localparam logic        MODE_READ   = 1'b0;
    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
    localparam int          RANDOM_WORDS = 1300;
    localparam int          HOT_SLOTS   = 16;

    // Mirror of the bucket memory and the replies it must produce, oldest first
    class store_mirror;
        typedef struct {
            status_t     st;
            logic [31:0] value;
        } reply_t;

        bit          valid_bits[ENTRY_COUNT];
        logic [31:0] key_bits[ENTRY_COUNT];
        logic [31:0] value_bits[ENTRY_COUNT];
        reply_t      pending[$];
        int          mismatches;

        function new();
            foreach (valid_bits[i])
                valid_bits[i] = 1'b0;
            mismatches = 0;
        endfunction

        // Apply one accepted request and queue the reply it causes
        function void note_request(logic m, logic [31:0] k, logic [31:0] d);
            logic [31:0] mag;
            int          base;
            int          hit;
            int          spare;
            reply_t      r;
            mag   = k[31] ? (32'd0 - k) : k;
            base  = int'(mag % BUCKETS) * WAY_COUNT;
            hit   = -1;
            spare = -1;
            for (int w = 0; w < WAY_COUNT; w++)
            begin
                if (valid_bits[base + w])
                begin
                    if (hit < 0 && key_bits[base + w] == k)
                        hit = w;
                end
                else if (spare < 0)
                begin
                    spare = w;
                end
            end
            r.value = NO_VALUE;
            if (m == MODE_READ)
            begin
                if (hit >= 0)
                begin
                    r.st    = STATUS_FOUND;
                    r.value = value_bits[base + hit];
                end
                else
                begin
                    r.st = STATUS_NOT_FOUND;
                end
            end
            else if (hit >= 0)
            begin
                value_bits[base + hit] = d;
                r.st = STATUS_WRITTEN;
            end
            else if (spare >= 0)
            begin
                valid_bits[base + spare] = 1'b1;
                key_bits[base + spare]   = k;
                value_bits[base + spare] = d;
                r.st = STATUS_WRITTEN;
            end
            else
            begin
                r.st = STATUS_FULL;
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted reply word with the oldest expectation
        task check_reply(logic [1:0] st, logic [31:0] v);
            reply_t r;
            if (pending.size() == 0)
            begin
                report($sformatf("reply status %0d data %h with no request outstanding", st, v));
            end
            else
            begin
                r = pending.pop_front();
                if (st !== r.st)
                    report($sformatf("status %0d, expected %0d", st, r.st));
                if (v !== r.value)
                    report($sformatf("data_out %h, expected %h", v, r.value));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        mode      = 1'b0;
    logic [31:0] key       = '0;
    logic [31:0] data_in   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] data_out;

    logic        steady_run = 1'b0;
    store_mirror mirror;
    logic [31:0] written_keys[$];
    int unsigned hot_bucket[HOT_SLOTS];

    hashed_key_value_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End the run as a failure if the block stops answering
    initial
    begin
        #3_000_000;
        $display("hashed_key_value_store regression: fail");
        $finish;
    end

    // Drive one request word and hold it until the block takes it
    task automatic send_request(input logic m, input logic [31:0] k, input logic [31:0] d);
        while (!steady_run && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        data_in  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mirror.note_request(m, k, d);
    endtask

    // Pick a fresh set of crowded buckets; keep the top bucket in play
    task automatic refresh_hot_buckets();
        foreach (hot_bucket[i])
            hot_bucket[i] = $urandom_range(0, BUCKETS - 1);
        hot_bucket[HOT_SLOTS - 1] = BUCKETS - 1;
    endtask

    // Mostly keys that collide in a few buckets or repeat earlier writes, some noise
    function automatic logic [31:0] pick_key();
        int unsigned roll;
        int unsigned mag;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return $urandom;
        if (roll < 50 && written_keys.size() > 0)
            return written_keys[$urandom_range(0, written_keys.size() - 1)];
        mag = hot_bucket[$urandom_range(0, HOT_SLOTS - 1)];
        if ($urandom_range(0, 9) == 0)
            mag += BUCKETS * $urandom_range(0, 2097151);
        else
            mag += BUCKETS * $urandom_range(0, 5);
        return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
    endfunction

    // Check every reply word and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                mirror.check_reply(status, data_out);
            out_stall <= !steady_run && ($urandom_range(0, 99) < 28);
        end
    end

    initial
    begin
        logic        m;
        logic [31:0] k;
        mirror = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Bucket zero: most negative key, zero and multiples of the bucket count
        send_request(MODE_READ,  32'd0,          32'd0);
        send_request(MODE_WRITE, KEY_MIN,        KEY_MAX);
        send_request(MODE_READ,  KEY_MIN,        32'd0);
        send_request(MODE_WRITE, 32'd0,          32'd0);
        send_request(MODE_WRITE, 32'd1024,       32'hFFFF_FFFF);
        send_request(MODE_WRITE, -32'sd1024,     KEY_MIN);
        // Bucket is full now: the write is refused and leaves no trace
        send_request(MODE_WRITE, 32'd2048,       32'd5);
        send_request(MODE_READ,  32'd2048,       32'd0);
        send_request(MODE_READ,  -32'sd1024,     32'd0);
        // Overwrite an existing key in place
        send_request(MODE_WRITE, 32'd0,          32'h5A5A_5A5A);
        send_request(MODE_READ,  32'd0,          32'd0);
        // Top bucket, and a key that shares it but was never written
        send_request(MODE_WRITE, KEY_MAX,        32'hA5A5_A5A5);
        send_request(MODE_READ,  KEY_MAX,        32'd0);
        send_request(MODE_READ,  32'h8000_0001,  32'd0);
        // Opposite signs are different keys in the same bucket
        send_request(MODE_WRITE, 32'hFFFF_FFFF,  32'd1);
        send_request(MODE_READ,  32'd1,          32'd0);
        send_request(MODE_READ,  32'hFFFF_FFFF,  32'd0);
        // Read ignores data_in
        send_request(MODE_READ,  KEY_MIN,        32'hDEAD_BEEF);

        // Random mix; a quiet stretch in the middle has no idling on either side
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 250 == 0)
                refresh_hot_buckets();
            if (n == 500)
                steady_run <= 1'b1;
            if (n == 800)
                steady_run <= 1'b0;
            m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
            k = pick_key();
            if (m == MODE_WRITE)
            begin
                written_keys.push_back(k);
                if (written_keys.size() > 64)
                    void'(written_keys.pop_front());
            end
            send_request(m, k, $urandom);
        end
        in_valid <= 1'b0;

        // Drain the outstanding replies, then let the pipeline settle
        while (mirror.pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("hashed_key_value_store regression: pass");
        else
            $display("hashed_key_value_store regression: fail");
        $finish;
    end
endmodule
